>>> src/matrix4x4_inverse_defines.svh
// assertion macros for the 4x4 matrix inverse block
// used by the top level only
`ifndef MATRIX4X4_INVERSE_DEFINES_SVH
`define MATRIX4X4_INVERSE_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define MI_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a condition implies a consequence on the next edge
`define MI_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> src/mi_pkg.sv
// shared constants and types for the 4x4 matrix inverse
// no dependencies
`timescale 1ns / 1ps
package mi_pkg;
  localparam int unsigned N_ELEM = 16;
  localparam int unsigned IDX_W  = 4;
  typedef logic [IDX_W-1:0] idx_t;
endpackage

>>> src/mi_ram.sv
// generic single-port write, single-port read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module mi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> src/mi_div.sv
// restoring divider, one quotient bit per cycle, unsigned
// no dependencies
`timescale 1ns / 1ps
module mi_div #(
  parameter int unsigned NW = 200,
  parameter int unsigned DW = 200
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt, done_r, done_nxt;
  logic [DW:0]   sh;
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; run_nxt = run_r; done_nxt = 1'b0;
    sh = {rem_r[DW-1:0], q_r[NW-1]};
    if (go) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = CW'(NW); run_nxt = 1'b1;
    end else if (run_r) begin
      if (sh >= {1'b0, den}) begin
        rem_nxt = sh - {1'b0, den};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      run_r <= run_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
  end
  assign done = done_r;
  assign quo  = q_r;
endmodule

>>> src/matrix4x4_inverse.sv
// 4x4 matrix inverse by adjugate over cofactors, fixed point; uses mi_pkg, mi_ram, mi_div
// items below position 15 are stored only; the position 15 item also copies the matrix,
// runs 148 products on one shared multiplier, then 16 divides
// busy until the last result leaves; receiver cannot stall, results never wait
// reset clears control state only; matrix contents are undefined until written
`timescale 1ns / 1ps
`include "matrix4x4_inverse_defines.svh"
module matrix4x4_inverse import mi_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ELEM_WIDTH-1:0] in_element,
  input  logic [3:0]                   in_position,
  output logic                         out_valid,
  output logic signed [ELEM_WIDTH-1:0] out_value,
  output logic [3:0]                   out_out_position,
  output logic                         out_last,
  output logic                         out_singular,
  output logic                         out_saturated
);
  // widths: 2x2 minor 2E+1, cofactor 3E+3, determinant 4E+4
  localparam int unsigned E   = ELEM_WIDTH;
  localparam int unsigned CW  = 3 * E + 3;
  localparam int unsigned DTW = 4 * E + 4;
  localparam int unsigned NW  = CW + 2 * FRAC_BITS + 2;
  localparam int unsigned DW  = DTW + 1;
  localparam int unsigned MW  = DTW;
  // multiplier walks the wide operand in 32-bit limbs, top limb first
  localparam int unsigned LW  = 32;
  localparam int unsigned NL  = (CW + LW - 1) / LW;
  localparam int unsigned XW  = NL * LW;
  localparam int unsigned KW  = $clog2(NL + 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_LOAD = 3'd1, S_COF = 3'd2, S_DET = 3'd3,
                         S_DIV = 3'd4, S_WAIT = 3'd5, S_OUT = 3'd6;

  logic [2:0] st_r, st_nxt;
  // matrix in ram, copied to a working register file for cofactor math
  logic        we;
  idx_t        raddr;
  logic [E-1:0] rdata;
  mi_ram #(.WIDTH(E), .DEPTH(N_ELEM)) u_ram (
    .clk(clk), .we(we), .waddr(in_position), .wdata(in_element),
    .raddr(raddr), .rdata(rdata));

  logic signed [E-1:0] m_r [N_ELEM];
  logic signed [CW-1:0] cof_r [N_ELEM];
  logic signed [DTW-1:0] det_r;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] k_r, k_nxt;       // term within cofactor
  logic [1:0] ph_r, ph_nxt;     // product within term
  logic signed [2*E:0] s_r;
  logic signed [CW-1:0] acc_r;
  logic signed [E-1:0] ma;
  logic signed [CW-1:0] mb;
  logic sing_r, dneg_r;
  logic div_go;
  logic div_done;
  logic [NW-1:0] quo;
  logic [NW-1:0] num;
  logic [DW-1:0] den;

  // shared multi-cycle multiplier state
  logic                  mul_go;
  logic                  mw_r;        // product in flight
  logic                  mul_done_r;
  logic                  mul_first_r;
  logic [KW-1:0]         mul_cnt_r;
  logic signed [E-1:0]   mul_a_r;
  logic [XW-1:0]         mul_b_r;
  logic [MW-1:0]         mul_p_r;
  logic signed [LW:0]    mul_lop;
  logic signed [E+LW:0]  mul_pp;

  assign busy = (st_r != S_IDLE);
  assign we   = start && !busy;

  // cofactor index helpers for current (row=cnt/4, col=cnt%4, term k)
  logic [1:0] row, col, r0, r1, r2, ck, c1, c2;
  function automatic logic [1:0] skip(input logic [1:0] x, input logic [1:0] n);
    skip = (n >= x) ? n + 2'd1 : n;
  endfunction
  always_comb begin
    row = cnt_r[3:2]; col = cnt_r[1:0];
    r0 = skip(row, 2'd0); r1 = skip(row, 2'd1); r2 = skip(row, 2'd2);
    ck = skip(col, k_r);
    c1 = skip(col, (k_r == 2'd2) ? 2'd0 : k_r + 2'd1);
    c2 = skip(col, (k_r == 2'd0) ? 2'd2 : k_r - 2'd1);
  end

  // multiplier operands: one element times a wide signed value
  always_comb begin
    ma = m_r[{2'd0, cnt_r[1:0]}]; mb = cof_r[{2'd0, cnt_r[1:0]}];
    if (st_r == S_COF) begin
      unique case (ph_r)
        2'd0: begin ma = m_r[{r1, c1}]; mb = CW'(m_r[{r2, c2}]); end
        2'd1: begin ma = m_r[{r1, c2}]; mb = CW'(m_r[{r2, c1}]); end
        default: begin ma = m_r[{r0, ck}]; mb = CW'(s_r); end
      endcase
    end
  end

  // each product is a load, then a pass over each limb, then a done strobe
  assign mul_go = (st_r == S_COF || st_r == S_DET) && !mw_r;
  always_comb begin
    mul_lop = mul_first_r ? {mul_b_r[XW-1], mul_b_r[XW-1 -: LW]}
                          : {1'b0, mul_b_r[XW-1 -: LW]};
    mul_pp  = mul_a_r * mul_lop;
  end

  // running sums finished by the product that is ready now
  logic signed [CW-1:0] term_sum;
  logic signed [DTW-1:0] det_sum;
  assign term_sum = CW'(mul_p_r) + ((k_r == 2'd0) ? CW'(0) : acc_r);
  assign det_sum  = DTW'(mul_p_r) + ((cnt_r == 5'd0) ? DTW'(0) : det_r);

  // divider operands: |cof|*2^(2F+1)+|det| over 2|det|
  logic signed [CW-1:0] cur_cof;
  logic [CW-1:0] acof;
  logic [DTW-1:0] adet;
  assign cur_cof = cof_r[{cnt_r[1:0], cnt_r[3:2]}];
  assign acof = cur_cof[CW-1] ? CW'(-cur_cof) : cur_cof;
  assign adet = det_r[DTW-1] ? DTW'(-det_r) : det_r;
  assign num  = (NW'(acof) << (2 * FRAC_BITS + 1)) + NW'(adet);
  assign den  = {adet, 1'b0};

  mi_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(num), .den(den),
    .done(div_done), .quo(quo));

  assign div_go = (st_r == S_DIV);

  // saturation of the quotient
  logic neg;
  logic [NW-1:0] lim;
  logic [E-1:0] val;
  logic sat;
  always_comb begin
    neg = cur_cof[CW-1] != dneg_r;
    lim = (NW'(1) << (E - 1)) - (neg ? NW'(0) : NW'(1));
    sat = quo > lim;
    val = sat ? E'(lim) : E'(quo);
    if (neg) val = E'(-val);
  end

  logic o_valid_r;
  logic [E-1:0] o_val_r;
  logic [3:0] o_pos_r;
  logic o_sat_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; k_nxt = k_r; ph_nxt = ph_r; raddr = cnt_r[3:0];
    unique case (st_r)
      S_IDLE: if (we && in_position == 4'd15) begin st_nxt = S_LOAD; cnt_nxt = '0; end
      S_LOAD: begin cnt_nxt = cnt_r + 5'd1; if (cnt_r == 5'd16) begin
          st_nxt = S_COF; cnt_nxt = '0; k_nxt = '0; ph_nxt = '0; end end
      S_COF: if (mul_done_r) begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          ph_nxt = '0; k_nxt = k_r + 2'd1;
          if (k_r == 2'd2) begin
            k_nxt = '0; cnt_nxt = cnt_r + 5'd1;
            if (cnt_r == 5'd15) begin st_nxt = S_DET; cnt_nxt = '0; end
          end
        end
      end
      S_DET: if (mul_done_r) begin cnt_nxt = cnt_r + 5'd1; if (cnt_r == 5'd3) begin
          st_nxt = S_DIV; cnt_nxt = '0; end end
      S_DIV: st_nxt = sing_r ? S_OUT : S_WAIT;
      S_WAIT: if (div_done) st_nxt = S_OUT;
      S_OUT: begin cnt_nxt = cnt_r + 5'd1;
        st_nxt = (cnt_r == 5'd15) ? S_IDLE : S_DIV; end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; k_r <= '0; ph_r <= '0; o_valid_r <= 1'b0;
      mw_r <= 1'b0; mul_done_r <= 1'b0; mul_cnt_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; k_r <= k_nxt; ph_r <= ph_nxt;
      o_valid_r <= (st_r == S_OUT);
      mw_r <= mul_go || (mw_r && !mul_done_r);
      mul_done_r <= !mul_go && mul_cnt_r == KW'(1);
      if (mul_go) mul_cnt_r <= KW'(NL);
      else if (mul_cnt_r != '0) mul_cnt_r <= mul_cnt_r - KW'(1);
    end
    // multiplier: signed top limb first, then unsigned limbs shifted in
    if (mul_go) begin
      mul_a_r <= ma; mul_b_r <= XW'(mb); mul_first_r <= 1'b1;
    end else if (mul_cnt_r != '0) begin
      mul_b_r <= mul_b_r << LW; mul_first_r <= 1'b0;
      mul_p_r <= mul_first_r ? MW'(mul_pp) : (mul_p_r << LW) + MW'(mul_pp);
    end
    // ram read data is registered, so it lands in the cycle after its address
    if (st_r == S_LOAD && cnt_r != 5'd0) m_r[4'(cnt_r - 5'd1)] <= rdata;
    if (st_r == S_COF && mul_done_r) begin
      unique case (ph_r)
        2'd0: s_r <= (2*E+1)'(mul_p_r);
        2'd1: s_r <= s_r - (2*E+1)'(mul_p_r);
        default: begin
          acc_r <= term_sum;
          if (k_r == 2'd2) cof_r[cnt_r[3:0]] <= (row[0] ^ col[0]) ? -term_sum : term_sum;
        end
      endcase
    end
    if (st_r == S_DET && mul_done_r) begin
      det_r <= det_sum;
      if (cnt_r == 5'd3) begin
        sing_r <= (det_sum == '0);
        dneg_r <= det_sum[DTW-1];
      end
    end
    if (st_r == S_OUT) begin
      o_val_r <= sing_r ? '0 : val;
      o_sat_r <= sing_r ? 1'b0 : sat;
      o_pos_r <= cnt_r[3:0];
    end
  end

  assign out_valid        = o_valid_r;
  assign out_value        = o_val_r;
  assign out_out_position = o_pos_r;
  assign out_last         = o_valid_r && o_pos_r == 4'd15;
  assign out_singular     = o_valid_r && sing_r;
  assign out_saturated    = o_sat_r;

  `MI_ASSERT_IMP(a_no_accept_busy, busy, !we)
  `MI_ASSERT_NXT(a_out_from_state, st_r == S_OUT, out_valid)
  `MI_ASSERT_IMP(a_last_valid, out_last, out_valid)
endmodule
